// ----- design/cppb_pkg.sv -----
package cppb_pkg;

   localparam int BUFFER_DEPTH = 64;
   localparam int ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int LEN_W = $clog2(BUFFER_DEPTH + 1);
   localparam int SPIKE_W = 32;
   localparam int COUNT_W = 8;
   localparam int QUEUE_DEPTH = 2;

   // request type codes
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_READ = 1'b1;

   // result kind codes
   localparam logic KIND_WRITE_ACK = 1'b0;
   localparam logic KIND_READ_DATA = 1'b1;

   // register indexes
   localparam logic REG_WRITER_COUNT = 1'b0;
   localparam logic REG_READER_COUNT = 1'b1;

   typedef struct packed {
      logic               is_read;
      logic [SPIKE_W-1:0] value;
      logic               has_data;
      logic               last_turn;
   } cmd_type;

   typedef struct packed {
      logic               result_kind;
      logic [SPIKE_W-1:0] spike_out;
      logic               data_valid;
      logic               last_result;
      logic               violation;
      logic               overflow;
      logic               phase;
   } rsp_type;

endpackage

// ----- design/cppb_front.sv -----
module cppb_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [cppb_pkg::SPIKE_W-1:0]          req_tdata,
   input  logic [1:0]                            req_tuser,
   input  logic                                  req_tlast,
   output logic                                  cmd_valid,
   input  logic                                  cmd_ready,
   output cppb_pkg::cmd_type                     cmd
);
   import cppb_pkg::*;

   logic    in_valid_ff, in_valid_in;
   cmd_type cmd_ff, cmd_in;
   logic    accept;

   assign req_tready = !in_valid_ff || cmd_ready;
   assign accept = req_tvalid && req_tready;

   always_comb begin
      cmd_in = cmd_ff;
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
         cmd_in.is_read = (req_tuser[0] == REQ_READ);
         cmd_in.value = req_tdata;
         // fill and turn markers only mean something on a write
         cmd_in.has_data = (req_tuser[0] == REQ_WRITE) && req_tuser[1];
         cmd_in.last_turn = (req_tuser[0] == REQ_WRITE) && req_tlast;
      end else if (cmd_ready) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      cmd_ff <= cmd_in;
   end

   assign cmd_valid = in_valid_ff;
   assign cmd = cmd_ff;

endmodule

// ----- design/cppb_queue.sv -----
module cppb_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  cppb_pkg::cmd_type in_cmd,
   output logic              out_valid,
   input  logic              out_ready,
   output cppb_pkg::cmd_type out_cmd
);
   import cppb_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            ent_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push, pop;

   assign in_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;
   assign out_cmd = ent_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10: count_in = count_ff + 1'b1;
         2'b01: count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         ent_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

// ----- design/cppb_back.sv -----
module cppb_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             cmd_valid,
   output logic                             cmd_ready,
   input  cppb_pkg::cmd_type                cmd,
   input  logic                             csr_we,
   input  logic                             csr_index,
   input  logic [cppb_pkg::COUNT_W-1:0]     csr_wdata,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output cppb_pkg::rsp_type                rsp
);
   import cppb_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_FETCH = 3'b010,
      ST_LOAD  = 3'b100
   } state_type;

   state_type          st_ff, st_in;
   logic [LEN_W-1:0]   len_a_ff, len_a_in, len_b_ff, len_b_in;
   logic [COUNT_W-1:0] wdone_a_ff, wdone_a_in, wdone_b_ff, wdone_b_in;
   logic [COUNT_W-1:0] rdone_a_ff, rdone_a_in, rdone_b_ff, rdone_b_in;
   logic               phase_ff, phase_in;
   logic [COUNT_W-1:0] writer_count_ff, reader_count_ff;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   logic [LEN_W-1:0]   n_ff, n_in;
   logic               side_ff, side_in;    // 1: streaming side B
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [SPIKE_W-1:0] mem_a [BUFFER_DEPTH];
   logic [SPIKE_W-1:0] mem_b [BUFFER_DEPTH];
   logic [SPIKE_W-1:0] rd_a_ff, rd_b_ff;

   logic               mem_we, mem_sel_a;
   logic [ADDR_W-1:0]  mem_addr;

   logic               out_free, take, swap_test;
   logic [LEN_W-1:0]   w_len, r_len;
   logic [COUNT_W-1:0] w_done, r_done, w_done_n, r_done_n;
   logic               viol, full, last_el;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign cmd_ready = (st_ff == ST_IDLE) && out_free;
   assign take = cmd_valid && cmd_ready;

   // phase 0 writes B and reads A
   assign w_len = phase_ff ? len_a_ff : len_b_ff;
   assign w_done = phase_ff ? wdone_a_ff : wdone_b_ff;
   assign r_len = phase_ff ? len_b_ff : len_a_ff;
   assign r_done = phase_ff ? rdone_b_ff : rdone_a_ff;
   assign full = (w_len >= LEN_W'(BUFFER_DEPTH));
   assign mem_addr = w_len[ADDR_W-1:0];
   assign last_el = (({1'b0, idx_ff} + 1'b1) == n_ff);

   always_comb begin
      st_in = st_ff;
      len_a_in = len_a_ff;
      len_b_in = len_b_ff;
      wdone_a_in = wdone_a_ff;
      wdone_b_in = wdone_b_ff;
      rdone_a_in = rdone_a_ff;
      rdone_b_in = rdone_b_ff;
      phase_in = phase_ff;
      idx_in = idx_ff;
      n_in = n_ff;
      side_in = side_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mem_we = 1'b0;
      mem_sel_a = phase_ff;
      swap_test = 1'b0;
      viol = 1'b0;
      w_done_n = w_done;
      r_done_n = r_done;

      case (st_ff)
         ST_IDLE: begin
            if (take && !cmd.is_read) begin
               viol = (w_done >= writer_count_ff);
               w_done_n = w_done + COUNT_W'(!viol && cmd.last_turn);
               mem_we = !viol && cmd.has_data && !full;
               if (phase_ff) begin
                  wdone_a_in = w_done_n;
                  if (mem_we) len_a_in = len_a_ff + 1'b1;
               end else begin
                  wdone_b_in = w_done_n;
                  if (mem_we) len_b_in = len_b_ff + 1'b1;
               end
               swap_test = cmd.last_turn;
            end else if (take) begin
               viol = (r_done >= reader_count_ff);
               r_done_n = r_done + COUNT_W'(!viol);
               if (phase_ff) rdone_b_in = r_done_n;
               else rdone_a_in = r_done_n;
               swap_test = 1'b1;
            end
         end
         ST_FETCH: begin
            st_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in.result_kind = KIND_READ_DATA;
               rsp_in.spike_out = side_ff ? rd_b_ff : rd_a_ff;
               rsp_in.data_valid = 1'b1;
               rsp_in.last_result = last_el;
               rsp_in.violation = 1'b0;
               rsp_in.overflow = 1'b0;
               rsp_in.phase = phase_ff;
               if (last_el) begin
                  st_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  st_in = ST_FETCH;
               end
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase

      // swap tested on the updated counts; the side just read keeps its data
      if (swap_test) begin
         if (!phase_ff) begin
            if (wdone_b_in >= writer_count_ff && rdone_a_in >= reader_count_ff) begin
               rdone_b_in = '0;
               wdone_a_in = '0;
               len_a_in = '0;
               phase_in = 1'b1;
            end
         end else begin
            if (wdone_a_in >= writer_count_ff && rdone_b_in >= reader_count_ff) begin
               rdone_a_in = '0;
               wdone_b_in = '0;
               len_b_in = '0;
               phase_in = 1'b0;
            end
         end
      end

      if (take && !cmd.is_read) begin
         rsp_valid_in = 1'b1;
         rsp_in.result_kind = KIND_WRITE_ACK;
         rsp_in.spike_out = '0;
         rsp_in.data_valid = 1'b0;
         rsp_in.last_result = 1'b1;
         rsp_in.violation = viol;
         rsp_in.overflow = !viol && cmd.has_data && full;
         rsp_in.phase = phase_in;
      end else if (take) begin
         if (viol || r_len == '0) begin
            rsp_valid_in = 1'b1;
            rsp_in.result_kind = KIND_READ_DATA;
            rsp_in.spike_out = '0;
            rsp_in.data_valid = 1'b0;
            rsp_in.last_result = 1'b1;
            rsp_in.violation = viol;
            rsp_in.overflow = 1'b0;
            rsp_in.phase = phase_in;
         end else begin
            idx_in = '0;
            n_in = r_len;
            side_in = phase_ff;
            st_in = ST_FETCH;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         len_a_ff <= '0;
         len_b_ff <= '0;
         wdone_a_ff <= '0;
         wdone_b_ff <= '0;
         rdone_a_ff <= '0;
         rdone_b_ff <= '0;
         phase_ff <= 1'b0;
         writer_count_ff <= COUNT_W'(1);
         reader_count_ff <= COUNT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         len_a_ff <= len_a_in;
         len_b_ff <= len_b_in;
         wdone_a_ff <= wdone_a_in;
         wdone_b_ff <= wdone_b_in;
         rdone_a_ff <= rdone_a_in;
         rdone_b_ff <= rdone_b_in;
         phase_ff <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && csr_index == REG_WRITER_COUNT) writer_count_ff <= csr_wdata;
         if (csr_we && csr_index == REG_READER_COUNT) reader_count_ff <= csr_wdata;
      end
      idx_ff <= idx_in;
      n_ff <= n_in;
      side_ff <= side_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we && mem_sel_a) mem_a[mem_addr] <= cmd.value;
      if (st_ff == ST_FETCH) rd_a_ff <= mem_a[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (mem_we && !mem_sel_a) mem_b[mem_addr] <= cmd.value;
      if (st_ff == ST_FETCH) rd_b_ff <= mem_b[idx_ff];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

endmodule

// ----- design/counted_ping_pong_buffer.sv -----
// channel  | direction | handshake              | payload
// req_     | in        | req_tvalid/req_tready  | tdata spike, tuser type+has_data, tlast
// rsp_     | out       | rsp_tvalid/rsp_tready  | tdata data+flags, tuser kind+valid, tlast
// csr_     | in        | csr_we                 | csr_index, csr_wdata
//
// A write is handled in the execute stage; a read is accepted there, then each element
// streamed passes the fetch and load states, set by the registered read of the side store.
// Front register and two-entry queue absorb stalls. Synchronous reset clears done counts
// and lengths at once and sets writer and reader counts to 1; store contents stay unknown.
// A held result (rsp_tready low) stalls the execute stage only; requests queue until full.
module counted_ping_pong_buffer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [cppb_pkg::SPIKE_W-1:0]     req_tdata,   // [31:0] spike_value
   input  logic [1:0]                       req_tuser,   // [0] req_type, [1] has_data
   input  logic                             req_tlast,   // last_of_turn
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [31:0] spike_out, [32] violation, [33] overflow, [34] phase, [39:35] zero
   output logic [39:0]                      rsp_tdata,
   output logic [1:0]                       rsp_tuser,   // [0] result_kind, [1] data_valid
   output logic                             rsp_tlast,   // last_result
   input  logic                             csr_we,
   input  logic                             csr_index,
   input  logic [cppb_pkg::COUNT_W-1:0]     csr_wdata
);
   import cppb_pkg::*;

   logic    f_valid, f_ready, q_valid, q_ready;
   cmd_type f_cmd, q_cmd;
   rsp_type rsp;

   cppb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .cmd_valid  (f_valid),
      .cmd_ready  (f_ready),
      .cmd        (f_cmd)
   );

   cppb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_cmd    (f_cmd),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_cmd   (q_cmd)
   );

   cppb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_valid),
      .cmd_ready (q_ready),
      .cmd       (q_cmd),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tdata = {5'b0, rsp.phase, rsp.overflow, rsp.violation, rsp.spike_out};
   assign rsp_tuser = {rsp.data_valid, rsp.result_kind};
   assign rsp_tlast = rsp.last_result;

endmodule

// ----- verif/tb_counted_ping_pong_buffer.sv -----
`timescale 1ns / 1ps

module tb_counted_ping_pong_buffer;
   import cppb_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int DRAIN_CYCLES = 20;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DIR_ROWS = 13;
   localparam int NUM_PHASES = 8;
   localparam int PH_WRITERS [NUM_PHASES] = '{1, 2, 255, 1, 1, 255, 0, 0};
   localparam int PH_READERS [NUM_PHASES] = '{1, 3, 1, 1, 255, 255, 0, 0};
   localparam int PH_ITEMS [NUM_PHASES] = '{30, 40, 90, 30, 30, 20, 35, 35};
   localparam int PH_READ_PCT [NUM_PHASES] = '{20, 25, 5, 25, 30, 20, 20, 20};

   typedef struct {
      cmd_type cmd;
      bit      typed;
      logic    viol;
      logic    ph;
   } dir_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [SPIKE_W-1:0]   req_tdata = '0;
   logic [1:0]           req_tuser = '0;
   logic                 req_tlast = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [39:0]          rsp_tdata;
   logic [1:0]           rsp_tuser;
   logic                 rsp_tlast;
   logic                 csr_we = 1'b0;
   logic                 csr_index = REG_WRITER_COUNT;
   logic [COUNT_W-1:0]   csr_wdata = '0;

   // buffer image kept alongside the block; index 0 is side A, 1 is side B
   logic [SPIKE_W-1:0]   side_store [2][BUFFER_DEPTH];
   logic [LEN_W-1:0]     side_len [2];
   logic [COUNT_W-1:0]   writes_done [2];
   logic [COUNT_W-1:0]   reads_done [2];
   logic                 cur_phase;
   logic [COUNT_W-1:0]   writer_limit;
   logic [COUNT_W-1:0]   reader_limit;

   rsp_type              awaited_results [$];
   int                   mismatches = 0;
   int                   cycles = 0;
   bit                   no_idle = 1'b0;
   bit                   hold_trigger = 1'b0;
   bit                   hold_taken = 1'b0;
   int                   hold_left = 0;
   dir_row_type          dir_table [DIR_ROWS];

   always #4 clock = ~clock;

   counted_ping_pong_buffer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   function automatic rsp_type make_result(input logic kind, input logic [SPIKE_W-1:0] data,
                                           input logic valid, input logic last,
                                           input logic viol, input logic ovf,
                                           input logic ph);
      rsp_type res;
      res.result_kind = kind;
      res.spike_out = data;
      res.data_valid = valid;
      res.last_result = last;
      res.violation = viol;
      res.overflow = ovf;
      res.phase = ph;
      return res;
   endfunction

   function automatic cmd_type make_request(input logic is_read, input logic [SPIKE_W-1:0] value,
                                            input logic has, input logic last);
      cmd_type cmd;
      cmd.is_read = is_read;
      cmd.value = value;
      cmd.has_data = has;
      cmd.last_turn = last;
      return cmd;
   endfunction

   function automatic dir_row_type dir_row(input logic is_read, input logic [SPIKE_W-1:0] value,
                                           input logic has, input logic last, input bit typed,
                                           input logic viol, input logic ph);
      dir_row_type row;
      row.cmd = make_request(is_read, value, has, last);
      row.typed = typed;
      row.viol = viol;
      row.ph = ph;
      return row;
   endfunction

   // sides swap once both counts are complete; the new write side starts empty
   function automatic void try_side_swap();
      int w;
      int r;
      w = cur_phase ? 0 : 1;
      r = cur_phase ? 1 : 0;
      if (writes_done[w] >= writer_limit && reads_done[r] >= reader_limit) begin
         reads_done[w] = '0;
         writes_done[r] = '0;
         side_len[r] = '0;
         cur_phase = ~cur_phase;
      end
   endfunction

   function automatic int predict_buffer_request(input cmd_type cmd, input bit record);
      int   w;
      int   r;
      int   n;
      logic viol;
      logic ovf;
      viol = 1'b0;
      ovf = 1'b0;
      n = 0;
      if (cmd.is_read == REQ_WRITE) begin
         w = cur_phase ? 0 : 1;
         if (writes_done[w] >= writer_limit) begin
            viol = 1'b1;
         end else begin
            if (cmd.has_data) begin
               if (side_len[w] >= BUFFER_DEPTH) begin
                  ovf = 1'b1;
               end else begin
                  side_store[w][side_len[w][ADDR_W-1:0]] = cmd.value;
                  side_len[w] = side_len[w] + 1'b1;
               end
            end
            if (cmd.last_turn) writes_done[w] = writes_done[w] + 1'b1;
         end
         if (cmd.last_turn) try_side_swap();
         if (record) awaited_results.push_back(
            make_result(KIND_WRITE_ACK, '0, 1'b0, 1'b1, viol, ovf, cur_phase));
         return 1;
      end
      r = cur_phase ? 1 : 0;
      if (reads_done[r] >= reader_limit) begin
         viol = 1'b1;
      end else begin
         n = (side_len[r] > BUFFER_DEPTH) ? BUFFER_DEPTH : int'(side_len[r]);
         reads_done[r] = reads_done[r] + 1'b1;
      end
      // store contents survive a swap, so the stream is read after it
      try_side_swap();
      if (n == 0) begin
         if (record) awaited_results.push_back(
            make_result(KIND_READ_DATA, '0, 1'b0, 1'b1, viol, 1'b0, cur_phase));
         return 1;
      end
      if (record) begin
         for (int i = 0; i < n; i++)
            awaited_results.push_back(make_result(KIND_READ_DATA, side_store[r][i], 1'b1,
                                                  (i == n - 1), 1'b0, 1'b0, cur_phase));
      end
      return n;
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatches < 100) $display("mismatch @%0t: %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic check_result();
      rsp_type want;
      rsp_type got;
      got = make_result(rsp_tuser[0], rsp_tdata[31:0], rsp_tuser[1], rsp_tlast,
                        rsp_tdata[32], rsp_tdata[33], rsp_tdata[34]);
      if (awaited_results.size() == 0) begin
         report_mismatch($sformatf("unexpected result %h", got));
      end else begin
         want = awaited_results.pop_front();
         if (got.result_kind !== want.result_kind || got.spike_out !== want.spike_out ||
             got.data_valid !== want.data_valid || got.last_result !== want.last_result ||
             got.violation !== want.violation || got.overflow !== want.overflow ||
             got.phase !== want.phase)
            report_mismatch($sformatf(
               "kind %b/%b data %h/%h dv %b/%b last %b/%b viol %b/%b ovf %b/%b ph %b/%b",
               got.result_kind, want.result_kind, got.spike_out, want.spike_out,
               got.data_valid, want.data_valid, got.last_result, want.last_result,
               got.violation, want.violation, got.overflow, want.overflow,
               got.phase, want.phase));
      end
   endtask

   // receiving side: checks each accepted result, stalls at random or for a long hold
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_result();
      if (hold_trigger && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left <= HOLD_OFF_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= no_idle || ($urandom_range(99) >= 31);
      end
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb_counted_ping_pong_buffer: FAIL");
      $finish;
   end

   // returns at the edge where the request is taken
   task automatic send_request(input cmd_type cmd);
      while (!no_idle && $urandom_range(99) < 31) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= cmd.value;
      req_tuser <= {cmd.has_data, cmd.is_read};
      req_tlast <= cmd.last_turn;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_counts(input logic [COUNT_W-1:0] wc, input logic [COUNT_W-1:0] rc);
      csr_we <= 1'b1;
      csr_index <= REG_WRITER_COUNT;
      csr_wdata <= wc;
      @(posedge clock);
      writer_limit = wc;
      csr_index <= REG_READER_COUNT;
      csr_wdata <= rc;
      @(posedge clock);
      reader_limit = rc;
      csr_we <= 1'b0;
   endtask

   task automatic wait_drained(input int extra);
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   function automatic cmd_type random_request(input int read_pct);
      cmd_type cmd;
      cmd.value = $urandom;
      if ($urandom_range(99) < read_pct) begin
         cmd.is_read = REQ_READ;
         cmd.has_data = 1'($urandom_range(1));
         cmd.last_turn = 1'($urandom_range(1));
      end else begin
         cmd.is_read = REQ_WRITE;
         cmd.has_data = ($urandom_range(9) != 0);
         cmd.last_turn = ($urandom_range(5) == 0);
      end
      return cmd;
   endfunction

   initial begin
      cmd_type          cmd;
      rsp_type          want;
      int               produced;
      logic [COUNT_W-1:0] wc;
      logic [COUNT_W-1:0] rc;

      for (int s = 0; s < 2; s++) begin
         side_len[s] = '0;
         writes_done[s] = '0;
         reads_done[s] = '0;
      end
      cur_phase = 1'b0;
      writer_limit = 8'd1;
      reader_limit = 8'd1;

      // typed rows: single results with no data, read straight off the rules
      dir_table[0]  = dir_row(REQ_READ,  32'h0000_0000, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
      dir_table[1]  = dir_row(REQ_READ,  32'h0000_0000, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
      dir_table[2]  = dir_row(REQ_WRITE, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
      dir_table[3]  = dir_row(REQ_WRITE, 32'h0000_0000, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
      dir_table[4]  = dir_row(REQ_WRITE, 32'h1234_5678, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1);
      dir_table[5]  = dir_row(REQ_READ,  32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
      dir_table[6]  = dir_row(REQ_READ,  32'h0000_0000, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
      dir_table[7]  = dir_row(REQ_WRITE, 32'hA5A5_A5A5, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
      dir_table[8]  = dir_row(REQ_WRITE, 32'h5A5A_5A5A, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
      dir_table[9]  = dir_row(REQ_WRITE, 32'hDEAD_BEEF, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0);
      dir_table[10] = dir_row(REQ_WRITE, 32'h0000_0000, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0);
      dir_table[11] = dir_row(REQ_READ,  32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      // swap just emptied side A; side B still holds the element written before it
      dir_table[12] = dir_row(REQ_READ,  32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIR_ROWS; i++) begin
         send_request(dir_table[i].cmd);
         produced = predict_buffer_request(dir_table[i].cmd, !dir_table[i].typed);
         if (dir_table[i].typed) begin
            want = make_result(dir_table[i].cmd.is_read, '0, 1'b0, 1'b1,
                               dir_table[i].viol, 1'b0, dir_table[i].ph);
            awaited_results.push_back(want);
            if (produced != 1) report_mismatch($sformatf("row %0d result count", i));
         end
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         req_tvalid <= 1'b0;
         wait_drained(12);
         if (p >= 6) begin
            wc = COUNT_W'($urandom_range(1, 2 * p - 8));
            rc = COUNT_W'($urandom_range(1, 2 * p - 8));
         end else begin
            wc = COUNT_W'(PH_WRITERS[p]);
            rc = COUNT_W'(PH_READERS[p]);
         end
         write_counts(wc, rc);
         no_idle = (p == 1);
         // long receiver stall while writes keep coming: block must back-pressure
         if (p == 2) hold_trigger = 1'b1;
         for (int k = 0; k < PH_ITEMS[p]; k++) begin
            cmd = random_request(PH_READ_PCT[p]);
            send_request(cmd);
            produced = predict_buffer_request(cmd, 1'b1);
         end
      end
      req_tvalid <= 1'b0;
      no_idle = 1'b0;

      wait_drained(DRAIN_CYCLES);
      if (mismatches == 0) begin
         $display("tb_counted_ping_pong_buffer: PASS");
      end else begin
         $display("tb_counted_ping_pong_buffer: FAIL");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
design/cppb_pkg.sv
design/cppb_front.sv
design/cppb_queue.sv
design/cppb_back.sv
design/counted_ping_pong_buffer.sv
verif/tb_counted_ping_pong_buffer.sv
